>>> design/mts_pkg.sv
// shared types, sizes and codes for the min-tracking stack
// no dependencies; compiled first
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int WORD_BITS   = VALUE_BITS + 2;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int FILL_BITS   = $clog2(STACK_DEPTH + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic signed [WORD_BITS-1:0]  word_t;
    typedef logic [FILL_BITS-1:0]         fill_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } mts_state_t;

endpackage

>>> design/mts_if.sv
// valid/ready channels for commands and results of the min-tracking stack
// depends on mts_pkg
interface mts_cmd_if
    import mts_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   kind;
    value_t value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mts_res_if
    import mts_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t top_value;
    logic   top_valid;
    value_t stack_min;
    logic   min_valid;
    fill_t  fill_level;
    logic   rejected;

    modport source (output valid, output top_value, output top_valid, output stack_min,
                    output min_valid, output fill_level, output rejected, input ready);
    modport sink   (input valid, input top_value, input top_valid, input stack_min,
                    input min_valid, input fill_level, input rejected, output ready);
endinterface

>>> design/min_tracking_stack_core.sv
// min-tracking stack: push and pop to or on empty finish in the idle state;
// other pops pass through ST_POP, where a registered read of the entry ram
// brings the new top word. one transaction at a time, taken once the result
// register is free or draining. reset clears fill count, minimum and state,
// not the entry ram, which needs no clearing: only written entries are read
// depends on mts_pkg, mts_if, mts_entry_ram
module min_tracking_stack_core
    import mts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mts_cmd_if.sink   cmd,
    mts_res_if.source res
);

    // control and architectural state
    mts_state_t state_reg, state_next;
    fill_t      sp_reg, sp_next;
    value_t     min_reg, min_next;
    // top word kept in flops, entries below it live in the ram
    word_t      top_word_reg, top_word_next;

    // result register
    logic   res_valid_reg, res_valid_next;
    value_t res_top_reg, res_min_reg;
    logic   res_nonempty_reg;
    fill_t  res_fill_reg;
    logic   res_rej_reg;

    // ram port
    logic  mem_we, mem_re;
    addr_t mem_waddr, mem_raddr;
    word_t mem_rdata;

    // result source selection
    logic   load_res;
    fill_t  src_sp;
    word_t  src_word;
    value_t src_min;
    logic   src_rej;
    word_t  src_min_ext;
    value_t src_top;

    // command decode
    logic   accept;
    logic   full;
    word_t  value_ext;
    word_t  min_ext;
    word_t  push_enc;
    word_t  pop_restore;
    value_t pop_min;

    function automatic addr_t mem_waddr_calc(fill_t sp);
        fill_t t;
        t = sp - fill_t'(1);
        return t[ADDR_BITS-1:0];
    endfunction

    function automatic addr_t mem_raddr_calc(fill_t sp);
        fill_t t;
        t = sp - fill_t'(2);
        return t[ADDR_BITS-1:0];
    endfunction

    mts_entry_ram #(
        .DEPTH(STACK_DEPTH),
        .WIDTH(WORD_BITS)
    ) u_entry_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(top_word_reg),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // ready when idle and the result slot is free or draining this cycle
    assign cmd.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (sp_reg == fill_t'(STACK_DEPTH));

    assign value_ext = word_t'(cmd.value);
    assign min_ext   = word_t'(min_reg);
    // new minimum is stored as 2*value - min, always below value
    assign push_enc  = (value_ext <<< 1) - min_ext;
    // popping an encoded word brings back the previous minimum as 2*min - word
    assign pop_restore = (min_ext <<< 1) - top_word_reg;
    assign pop_min     = (top_word_reg < min_ext) ? pop_restore[VALUE_BITS-1:0] : min_reg;

    // ram addresses: push spills the old top below, pop fetches the entry under it
    assign mem_waddr = mem_waddr_calc(sp_reg);
    assign mem_raddr = mem_raddr_calc(sp_reg);

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        min_next       = min_reg;
        top_word_next  = top_word_reg;
        res_valid_next = res_valid_reg && !res.ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        load_res       = 1'b0;
        src_sp         = sp_reg;
        src_word       = top_word_reg;
        src_min        = min_reg;
        src_rej        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_PUSH)
                    begin
                        if (full)
                        begin
                            src_rej = 1'b1;
                        end
                        else if (sp_reg == '0)
                        begin
                            top_word_next = value_ext;
                            min_next      = cmd.value;
                            sp_next       = fill_t'(1);
                        end
                        else
                        begin
                            mem_we  = 1'b1;
                            sp_next = sp_reg + fill_t'(1);
                            if (value_ext < min_ext)
                            begin
                                top_word_next = push_enc;
                                min_next      = cmd.value;
                            end
                            else
                            begin
                                top_word_next = value_ext;
                            end
                        end
                        load_res = 1'b1;
                        src_sp   = sp_next;
                        src_word = top_word_next;
                        src_min  = min_next;
                    end
                    else
                    begin
                        if (sp_reg == '0)
                        begin
                            // pop on empty: report the empty stack
                            load_res = 1'b1;
                        end
                        else if (sp_reg == fill_t'(1))
                        begin
                            // last entry leaves, minimum goes back to zero
                            sp_next  = '0;
                            min_next = '0;
                            load_res = 1'b1;
                            src_sp   = '0;
                            src_min  = '0;
                        end
                        else
                        begin
                            sp_next    = sp_reg - fill_t'(1);
                            min_next   = pop_min;
                            mem_re     = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_POP:
            begin
                // new top word arrives from the ram
                top_word_next = mem_rdata;
                load_res      = 1'b1;
                src_word      = mem_rdata;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
    end

    // an encoded word below the minimum decodes to the minimum itself
    assign src_min_ext = word_t'(src_min);
    assign src_top     = (src_word < src_min_ext) ? src_min : src_word[VALUE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            min_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            min_reg       <= min_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_word_reg <= top_word_next;
        if (load_res)
        begin
            res_nonempty_reg <= (src_sp != '0);
            res_top_reg      <= (src_sp != '0) ? src_top : '0;
            res_min_reg      <= (src_sp != '0) ? src_min : '0;
            res_fill_reg     <= src_sp;
            res_rej_reg      <= src_rej;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.top_value  = res_top_reg;
    assign res.top_valid  = res_nonempty_reg;
    assign res.stack_min  = res_min_reg;
    assign res.min_valid  = res_nonempty_reg;
    assign res.fill_level = res_fill_reg;
    assign res.rejected   = res_rej_reg;

endmodule

>>> design/mts_entry_ram.sv
// single-port-write, single-port-read synchronous ram, registered read data
// no package dependency
module mts_entry_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> test/min_tracking_stack_core_test.sv
// self-checking bench for min_tracking_stack_core: directed table, then random push/pop traffic
// depends on mts_pkg, mts_if and the core; its own stack model predicts every result not typed by hand
`timescale 1ns / 100ps

module min_tracking_stack_core_test;
    import mts_pkg::*;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam value_t POP_FILLER = {VALUE_BITS{1'b1}};
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASE_ITEMS = 300;
    localparam int FULL_TAIL = 40;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // who is allowed to idle in the current stretch of traffic
    typedef enum logic [1:0]
    {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_t;

    // one result transaction as the core reports it
    typedef struct packed
    {
        value_t top_value;
        logic   top_valid;
        value_t stack_min;
        logic   min_valid;
        fill_t  fill_level;
        logic   rejected;
    } stack_view_t;

    // one line of the directed script; typed rows carry a hand-written expectation
    typedef struct
    {
        logic        kind;
        value_t      value;
        bit          typed;
        stack_view_t view;
    } script_row_t;

    logic clk;
    logic rst_n;
    flow_t flow = FLOW_FREE;

    mts_cmd_if cmd_ch ();
    mts_res_if res_ch ();

    min_tracking_stack_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // shadow stack: words kept 64 bits wide, so the min encoding never wraps here
    longint held_words [STACK_DEPTH];
    longint floor_value = 0;
    int     held_count = 0;

    stack_view_t expected_views [$];
    script_row_t script [$];

    int failures = 0;
    int results_seen = 0;
    int push_count = 0;
    int pop_count = 0;
    int reject_count = 0;
    int encode_count = 0;
    int restore_count = 0;
    int deepest = 0;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("min_tracking_stack_core: mismatch");
        $finish;
    end

    // apply one operation to the shadow stack and return what the core should report
    function automatic stack_view_t apply_op(input logic kind, input value_t value);
        stack_view_t view;
        longint v;
        longint w;
        v = longint'(value);
        view = '0;
        if (kind == KIND_PUSH)
        begin
            push_count++;
            if (held_count >= STACK_DEPTH)
            begin
                // full: drop the value and flag it
                view.rejected = 1'b1;
                reject_count++;
            end
            else if (held_count == 0)
            begin
                held_words[0] = v;
                floor_value = v;
                held_count = 1;
            end
            else if (v < floor_value)
            begin
                // new minimum: store 2*v - old min, which sits below the new min
                held_words[held_count] = 2 * v - floor_value;
                floor_value = v;
                held_count++;
                encode_count++;
            end
            else
            begin
                held_words[held_count] = v;
                held_count++;
            end
        end
        else
        begin
            pop_count++;
            if (held_count > 0)
            begin
                w = held_words[held_count - 1];
                // an encoded word gives back the previous minimum
                if (w < floor_value)
                begin
                    floor_value = 2 * floor_value - w;
                    restore_count++;
                end
                held_count--;
                if (held_count == 0)
                begin
                    floor_value = 0;
                end
            end
        end
        if (held_count > 0)
        begin
            w = held_words[held_count - 1];
            view.top_value = value_t'((w < floor_value) ? floor_value : w);
            view.top_valid = 1'b1;
            view.stack_min = value_t'(floor_value);
            view.min_valid = 1'b1;
        end
        view.fill_level = fill_t'(held_count);
        if (held_count > deepest)
        begin
            deepest = held_count;
        end
        return view;
    endfunction

    // values clustered around the current minimum so new minimums and ties are common
    function automatic value_t pick_value();
        longint base;
        longint pick;
        int sel;
        base = (held_count == 0) ? 0 : floor_value;
        sel = $urandom_range(0, 15);
        case (sel)
            0: pick = longint'(VAL_MIN);
            1: pick = longint'(VAL_MAX);
            2: pick = base;
            3: pick = base - 1;
            4: pick = base + 1;
            5, 6, 7, 8: pick = base - longint'($urandom_range(1, 5000));
            9, 10: pick = base + longint'($urandom_range(0, 5000));
            default: pick = longint'(value_t'($urandom));
        endcase
        if (pick > longint'(VAL_MAX))
        begin
            pick = longint'(VAL_MAX);
        end
        if (pick < longint'(VAL_MIN))
        begin
            pick = longint'(VAL_MIN);
        end
        return value_t'(pick);
    endfunction

    task automatic add_row(input logic kind, input value_t value, input bit typed,
                           input value_t top, input value_t lowest, input int fill);
        script_row_t row;
        row.kind = kind;
        row.value = value;
        row.typed = typed;
        row.view = '0;
        row.view.top_value = top;
        row.view.stack_min = lowest;
        row.view.top_valid = (fill != 0);
        row.view.min_valid = (fill != 0);
        row.view.fill_level = fill_t'(fill);
        script.push_back(row);
    endtask

    // enter and leave at a falling edge; valid is only written once per edge
    task automatic send_op(input logic kind, input value_t value, input bit typed,
                           input stack_view_t typed_view);
        stack_view_t view;
        // sender gaps for the current phase
        while ((flow == FLOW_SEND_GAPS && $urandom_range(0, 99) < 52) ||
               (flow == FLOW_BOTH && $urandom_range(0, 99) < 25))
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.value <= value;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        // transaction taken: predict now so the expectation is queued in order
        view = apply_op(kind, value);
        expected_views.push_back(typed ? typed_view : view);
        @(negedge clk);
    endtask

    task automatic field_mismatch(input string field, input longint want, input longint got);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
        end
    endtask

    // result side: stall pattern follows the phase, decided at every falling edge
    initial
    begin : recv_side
        bit stall;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = (flow == FLOW_RECV_STALLS && $urandom_range(0, 99) < 52) ||
                    (flow == FLOW_BOTH && $urandom_range(0, 99) < 25);
            res_ch.ready <= !stall;
        end
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge clk)
    begin : result_check
        stack_view_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_views.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("result transaction at %0t with nothing outstanding", $time);
                end
            end
            else
            begin
                want = expected_views.pop_front();
                if (res_ch.top_value !== want.top_value)
                begin
                    field_mismatch("top_value", longint'(want.top_value),
                                   longint'(res_ch.top_value));
                end
                if (res_ch.top_valid !== want.top_valid)
                begin
                    field_mismatch("top_valid", longint'(want.top_valid),
                                   longint'(res_ch.top_valid));
                end
                if (res_ch.stack_min !== want.stack_min)
                begin
                    field_mismatch("stack_min", longint'(want.stack_min),
                                   longint'(res_ch.stack_min));
                end
                if (res_ch.min_valid !== want.min_valid)
                begin
                    field_mismatch("min_valid", longint'(want.min_valid),
                                   longint'(res_ch.min_valid));
                end
                if (res_ch.fill_level !== want.fill_level)
                begin
                    field_mismatch("fill_level", longint'(want.fill_level),
                                   longint'(res_ch.fill_level));
                end
                if (res_ch.rejected !== want.rejected)
                begin
                    field_mismatch("rejected", longint'(want.rejected),
                                   longint'(res_ch.rejected));
                end
            end
            results_seen++;
        end
    end

    // main stimulus
    initial
    begin : stimulus
        logic kind;
        int sent;
        int tail;
        bit seen_full;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = KIND_PUSH;
        cmd_ch.value = '0;
        rst_n = 1'b0;

        // directed script: empty pop, extremes, ties, nested minimums and their unwinding
        add_row(KIND_POP,  POP_FILLER, 1'b1, 0, 0, 0);             // pop on empty stack
        add_row(KIND_PUSH, VAL_MAX,    1'b1, VAL_MAX, VAL_MAX, 1); // push onto empty
        add_row(KIND_PUSH, VAL_MIN,    1'b1, VAL_MIN, VAL_MIN, 2); // widest encoded word
        add_row(KIND_POP,  POP_FILLER, 1'b1, VAL_MAX, VAL_MAX, 1); // min restored from it
        add_row(KIND_POP,  POP_FILLER, 1'b1, 0, 0, 0);             // back to empty
        add_row(KIND_PUSH, 0,          1'b1, 0, 0, 1);
        add_row(KIND_PUSH, 0,          1'b1, 0, 0, 2);             // equal to min
        add_row(KIND_PUSH, -1,         1'b1, -1, -1, 3);
        add_row(KIND_PUSH, 5,          1'b1, 5, -1, 4);
        add_row(KIND_PUSH, -1,         1'b1, -1, -1, 5);
        add_row(KIND_PUSH, VAL_MIN,    1'b1, VAL_MIN, VAL_MIN, 6);
        add_row(KIND_PUSH, VAL_MIN,    1'b1, VAL_MIN, VAL_MIN, 7);
        add_row(KIND_PUSH, VAL_MAX,    1'b1, VAL_MAX, VAL_MIN, 8);
        add_row(KIND_POP,  POP_FILLER, 1'b1, VAL_MIN, VAL_MIN, 7);
        add_row(KIND_POP,  POP_FILLER, 1'b1, VAL_MIN, VAL_MIN, 6); // encoded top decodes to min
        add_row(KIND_POP,  POP_FILLER, 1'b1, -1, -1, 5);
        add_row(KIND_POP,  POP_FILLER, 1'b1, 5, -1, 4);
        add_row(KIND_POP,  POP_FILLER, 1'b1, -1, -1, 3);
        add_row(KIND_POP,  POP_FILLER, 1'b1, 0, 0, 2);
        add_row(KIND_POP,  POP_FILLER, 1'b1, 0, 0, 1);
        add_row(KIND_PUSH, value_t'(32'h5555_5555), 1'b0, 0, 0, 0);
        add_row(KIND_PUSH, value_t'(32'hAAAA_AAAA), 1'b0, 0, 0, 0);
        add_row(KIND_POP,  0,          1'b0, 0, 0, 0);
        add_row(KIND_POP,  0,          1'b0, 0, 0, 0);
        add_row(KIND_POP,  POP_FILLER, 1'b1, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            send_op(script[i].kind, script[i].value, script[i].typed, script[i].view);
        end

        // random part: climb toward full with occasional pops, then hover at the top
        sent = 0;
        tail = FULL_TAIL;
        seen_full = 1'b0;
        while (sent < RANDOM_ITEMS || tail > 0)
        begin
            flow = flow_t'((sent / PHASE_ITEMS) % 4);
            // hold the sender until the core has drained, at phase starts and now and then
            if (sent % PHASE_ITEMS == 0 || $urandom_range(0, 63) == 0)
            begin
                while (expected_views.size() != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    @(negedge clk);
                end
            end
            if (!seen_full)
            begin
                kind = ($urandom_range(0, 15) == 0) ? KIND_POP : KIND_PUSH;
            end
            else
            begin
                kind = ($urandom_range(0, 1) == 0) ? KIND_POP : KIND_PUSH;
            end
            send_op(kind, pick_value(), 1'b0, '0);
            if (held_count == STACK_DEPTH)
            begin
                seen_full = 1'b1;
            end
            if (seen_full && tail > 0)
            begin
                tail--;
            end
            sent++;
        end
        cmd_ch.valid <= 1'b0;

        // let every outstanding result come back, then a short settle window
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d results checked over %0d pushes and %0d pops, deepest fill %0d",
                 results_seen, push_count, pop_count, deepest);
        $display("%0d pushes stored encoded, %0d minimum restores, %0d pushes dropped at full",
                 encode_count, restore_count, reject_count);
        if (failures == 0)
        begin
            $display("min_tracking_stack_core: match");
        end
        else
        begin
            $display("%0d failures", failures);
            $display("min_tracking_stack_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
design/mts_pkg.sv
design/mts_if.sv
design/mts_entry_ram.sv
design/min_tracking_stack_core.sv
test/min_tracking_stack_core_test.sv
